/* rtl/bss_pkg.sv */
// Package for the bubble sort swap count core.
// Holds field widths, the default capacity and the compare unit control struct.
// No dependencies.
package bss_pkg;

	localparam int DATA_W        = 32;
	localparam int CNT_W         = 11;
	localparam int MAX_ITEMS_DEF = 64;

	// Commands from the sequencer to the compare unit
	typedef struct packed {
		logic load;   // take the read data as the carried element
		logic step;   // compare read data with the carried element, count
		logic clear;  // zero the swap and compare counters
	} cmp_ctrl_t;

endpackage

/* rtl/bss_ram.sv */
// Generic single write port, single read port RAM with registered read data.
// Depends on nothing; width and depth come from parameters.
module bss_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* rtl/bss_cmp_unit.sv */
// Shared compare-and-select unit of the bubble sort core: holds the element
// carried toward the front in a pass and counts compares and swaps.
// Depends on bss_pkg.
module bss_cmp_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  bss_pkg::cmp_ctrl_t         ctrl,
	input  logic [bss_pkg::DATA_W-1:0] rd_data,
	output logic [bss_pkg::DATA_W-1:0] wr_data,
	output logic [bss_pkg::DATA_W-1:0] carry,
	output logic [bss_pkg::CNT_W-1:0]  swap_count,
	output logic [bss_pkg::CNT_W-1:0]  compare_count
);
	import bss_pkg::*;

	logic [DATA_W-1:0] carry_q;
	logic [CNT_W-1:0]  swap_q;
	logic [CNT_W-1:0]  cmp_q;
	logic              gt;

	// Front entry is strictly greater: it moves back, carried element stays
	assign gt      = $signed(rd_data) > $signed(carry_q);
	assign wr_data = gt ? rd_data : carry_q;

	// Hold the carried element
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			carry_q <= rd_data;
		end else if (ctrl.step && !gt) begin
			carry_q <= rd_data;
		end
	end

	// Count compares and swaps, saturating at all ones
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			swap_q <= '0;
			cmp_q  <= '0;
		end else if (ctrl.clear) begin
			swap_q <= '0;
			cmp_q  <= '0;
		end else if (ctrl.step) begin
			if (cmp_q != '1) begin
				cmp_q <= cmp_q + CNT_W'(1);
			end
			if (gt && swap_q != '1) begin
				swap_q <= swap_q + CNT_W'(1);
			end
		end
	end

	assign carry         = carry_q;
	assign swap_count    = swap_q;
	assign compare_count = cmp_q;

endmodule

/* rtl/bubble_sort_swap_count_core.sv */
// Bubble sort core with swap and compare counts.
//
// Input: an item (value, last_item) is taken at a clock edge where start is
// high and busy is low. Items are stored one per cycle; up to MAX_ITEMS are
// kept, later ones are dropped and raise overflow. An item with last_item
// set is stored (if room) and starts the sort; busy stays high until all
// results are out, then the core is empty and ready for a new set.
// Sort: one pass per front position i; each pass walks from the back with
// one RAM read, one compare and one RAM write per cycle, plus the pass
// overhead states PSTART, PLOAD and PEND and one final check in PSTART.
// The single RAM read/write port pair and the shared compare unit set
// this pace.
// Output: n results, one per cycle on result_valid, ascending, each with
// swap_count, compare_count and overflow; last_result marks the final one.
// Results start after the last pass writes back in PEND, by way of PSTART
// and OUT. The receiver cannot stall: each result is present for exactly
// one cycle.
// Reset (arst_n low) empties the store and clears counts and flags; the
// RAM contents are not cleared and are never read before being written.
// Depends on bss_pkg, bss_ram, bss_cmp_unit.
module bubble_sort_swap_count_core #(
	parameter int MAX_ITEMS = bss_pkg::MAX_ITEMS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic signed [bss_pkg::DATA_W-1:0] value,
	input  logic                              last_item,
	output logic                              result_valid,
	output logic signed [bss_pkg::DATA_W-1:0] sorted_value,
	output logic        [bss_pkg::CNT_W-1:0]  swap_count,
	output logic        [bss_pkg::CNT_W-1:0]  compare_count,
	output logic                              overflow,
	output logic                              last_result
);
	import bss_pkg::*;

	localparam int AW = $clog2(MAX_ITEMS);
	localparam int CW = $clog2(MAX_ITEMS + 1);

	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_PSTART = 7'b0000010,
		ST_PLOAD  = 7'b0000100,
		ST_PRUN   = 7'b0001000,
		ST_PEND   = 7'b0010000,
		ST_OUT    = 7'b0100000,
		ST_DRAIN  = 7'b1000000
	} state_t;

	state_t            state_q;
	logic [CW-1:0]     total_q;
	logic              dropped_q;
	logic [AW-1:0]     pass_q;
	logic [AW-1:0]     j_q;
	logic [AW-1:0]     k_q;
	logic              valid_s1;
	logic              last_s1;

	logic              accept;
	logic              has_room;
	logic [CW-1:0]     last_full;
	logic [AW-1:0]     last_idx;

	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [DATA_W-1:0] ram_wdata;
	logic [AW-1:0]     ram_raddr;
	logic [DATA_W-1:0] ram_rdata;

	cmp_ctrl_t         cmp_ctrl;
	logic [DATA_W-1:0] cmp_wr_data;
	logic [DATA_W-1:0] cmp_carry;

	assign busy      = (state_q != ST_IDLE);
	assign accept    = start && !busy;
	assign has_room  = (total_q < CW'(MAX_ITEMS));
	assign last_full = total_q - CW'(1);
	assign last_idx  = last_full[AW-1:0];

	// Element store
	bss_ram #(
		.WIDTH(DATA_W),
		.DEPTH(MAX_ITEMS)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Shared compare unit
	bss_cmp_unit u_cmp (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctrl         (cmp_ctrl),
		.rd_data      (ram_rdata),
		.wr_data      (cmp_wr_data),
		.carry        (cmp_carry),
		.swap_count   (swap_count),
		.compare_count(compare_count)
	);

	// Drive RAM ports and compare unit commands from the state
	always_comb begin
		ram_we         = 1'b0;
		ram_waddr      = total_q[AW-1:0];
		ram_wdata      = $unsigned(value);
		ram_raddr      = last_idx;
		cmp_ctrl.load  = 1'b0;
		cmp_ctrl.step  = 1'b0;
		cmp_ctrl.clear = 1'b0;
		case (state_q)
			ST_IDLE: begin
				ram_we = accept && has_room;
			end
			ST_PSTART: begin
				ram_raddr = last_idx;
			end
			ST_PLOAD: begin
				cmp_ctrl.load = 1'b1;
				ram_raddr     = j_q - AW'(1);
			end
			ST_PRUN: begin
				cmp_ctrl.step = 1'b1;
				ram_we        = 1'b1;
				ram_waddr     = j_q;
				ram_wdata     = cmp_wr_data;
				ram_raddr     = j_q - AW'(2);
			end
			ST_PEND: begin
				ram_we    = 1'b1;
				ram_waddr = pass_q;
				ram_wdata = cmp_carry;
			end
			ST_OUT: begin
				ram_raddr = k_q;
			end
			ST_DRAIN: begin
				cmp_ctrl.clear = 1'b1;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	// Sequencer: load, sort passes, output, clear
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			total_q   <= '0;
			dropped_q <= 1'b0;
			pass_q    <= '0;
			j_q       <= '0;
			k_q       <= '0;
			valid_s1  <= 1'b0;
			last_s1   <= 1'b0;
		end else begin
			valid_s1 <= 1'b0;
			last_s1  <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (has_room) begin
							total_q <= total_q + CW'(1);
						end else begin
							dropped_q <= 1'b1;
						end
						if (last_item) begin
							pass_q  <= '0;
							state_q <= ST_PSTART;
						end
					end
				end
				ST_PSTART: begin
					if (pass_q < last_idx) begin
						j_q     <= last_idx;
						state_q <= ST_PLOAD;
					end else begin
						k_q     <= '0;
						state_q <= ST_OUT;
					end
				end
				ST_PLOAD: begin
					state_q <= ST_PRUN;
				end
				ST_PRUN: begin
					j_q <= j_q - AW'(1);
					if (j_q == pass_q + AW'(1)) begin
						state_q <= ST_PEND;
					end
				end
				ST_PEND: begin
					pass_q  <= pass_q + AW'(1);
					state_q <= ST_PSTART;
				end
				ST_OUT: begin
					valid_s1 <= 1'b1;
					last_s1  <= (k_q == last_idx);
					k_q      <= k_q + AW'(1);
					if (k_q == last_idx) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					total_q   <= '0;
					dropped_q <= 1'b0;
					state_q   <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign result_valid = valid_s1;
	assign last_result  = last_s1;
	assign sorted_value = $signed(ram_rdata);
	assign overflow     = dropped_q;

	// Results appear only while the core is busy
	a_valid_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> busy)
		else $error("result strobe while idle");

	// A last item always starts a sort
	a_last_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && last_item) |=> busy)
		else $error("last item did not start a sort");

	// Final result mark only on a strobed result
	a_last_valid: assert property (@(posedge clk) disable iff (!arst_n)
		last_result |-> result_valid)
		else $error("last_result without result_valid");

	// Run ends cleared
	a_drain_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAIN) |=> (!busy && swap_count == '0 && total_q == '0
		&& !overflow))
		else $error("state not cleared after run");

endmodule

/* tb/tb_bubble_sort_swap_count_core.sv */
// Self-checking testbench for bubble_sort_swap_count_core: loads sets of signed
// values, predicts the sorted run with its swap and compare counts, checks every result.
// Depends on bss_pkg and the core RTL.
`timescale 1ns / 100ps

package bss_tb_pkg;

	import bss_pkg::*;

	typedef struct packed {
		logic signed [DATA_W-1:0] sorted_value;
		logic        [CNT_W-1:0]  swaps;
		logic        [CNT_W-1:0]  compares;
		logic                     dropped;
		logic                     tail;
	} sorted_entry_t;

	class sort_scoreboard;
		logic signed [DATA_W-1:0] held_values[$];
		bit                       drop_seen;
		sorted_entry_t            awaited_sorted[$];
		int                       fails;
		int                       results_seen;
		int                       sets_sorted;
		int                       overflow_sets;
		int                       largest_set;

		// Store an accepted item; on the item marked last, sort the set and queue its run
		function void note_item(logic signed [DATA_W-1:0] v, bit is_last);
			logic signed [DATA_W-1:0] arr[$];
			logic signed [DATA_W-1:0] tmp;
			int unsigned              n;
			int unsigned              swaps;
			int unsigned              cmps;
			sorted_entry_t            e;
			if (held_values.size() < MAX_ITEMS_DEF)
				held_values.push_back(v);
			else
				drop_seen = 1'b1;
			if (!is_last)
				return;
			arr   = held_values;
			n     = arr.size();
			swaps = 0;
			// Full bubble sort: each pass walks from the back toward the front
			for (int unsigned i = 0; i + 1 < n; i++) begin
				for (int unsigned j = n - 1; j > i; j--) begin
					if (arr[j-1] > arr[j]) begin
						tmp      = arr[j-1];
						arr[j-1] = arr[j];
						arr[j]   = tmp;
						swaps++;
					end
				end
			end
			cmps = (n > 0) ? n * (n - 1) / 2 : 0;
			// Saturate counts that do not fit the count fields
			if (swaps > (1 << CNT_W) - 1)
				swaps = (1 << CNT_W) - 1;
			if (cmps > (1 << CNT_W) - 1)
				cmps = (1 << CNT_W) - 1;
			for (int unsigned k = 0; k < n; k++) begin
				e.sorted_value = arr[k];
				e.swaps        = swaps[CNT_W-1:0];
				e.compares     = cmps[CNT_W-1:0];
				e.dropped      = drop_seen;
				e.tail         = (k + 1 == n);
				awaited_sorted.push_back(e);
			end
			sets_sorted++;
			if (drop_seen)
				overflow_sets++;
			if (n > largest_set)
				largest_set = n;
			held_values.delete();
			drop_seen = 1'b0;
		endfunction

		function void check_field(string name, longint exp_val, longint act_val);
			if (exp_val != act_val) begin
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name,
					exp_val, act_val);
				fails++;
			end
		endfunction

		// Compare one strobed result with the oldest queued expectation
		function void check_result(logic signed [DATA_W-1:0] sv, logic [CNT_W-1:0] sc,
			logic [CNT_W-1:0] cc, logic ov, logic lr);
			sorted_entry_t e;
			results_seen++;
			if (awaited_sorted.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual value %0d",
					$time, sv);
				fails++;
				return;
			end
			e = awaited_sorted.pop_front();
			check_field("sorted_value", e.sorted_value, sv);
			check_field("swap_count", e.swaps, sc);
			check_field("compare_count", e.compares, cc);
			check_field("overflow", e.dropped, ov);
			check_field("last_result", e.tail, lr);
		endfunction
	endclass

endpackage

module tb_bubble_sort_swap_count_core;

	import bss_pkg::*;
	import bss_tb_pkg::*;

	localparam int RANDOM_ITEMS = 96;

	logic                     clk       = 1'b0;
	logic                     arst_n    = 1'b0;
	logic                     start     = 1'b0;
	logic signed [DATA_W-1:0] value     = '0;
	logic                     last_item = 1'b0;
	logic                     busy;
	logic                     result_valid;
	logic signed [DATA_W-1:0] sorted_value;
	logic        [CNT_W-1:0]  swap_count;
	logic        [CNT_W-1:0]  compare_count;
	logic                     overflow;
	logic                     last_result;

	sort_scoreboard board;
	int             burst_left;
	int             items_sent;

	bubble_sort_swap_count_core DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.value        (value),
		.last_item    (last_item),
		.result_valid (result_valid),
		.sorted_value (sorted_value),
		.swap_count   (swap_count),
		.compare_count(compare_count),
		.overflow     (overflow),
		.last_result  (last_result)
	);

	always #5 clk = ~clk;

	// Check every strobed result at the edge that ends its cycle
	always @(posedge clk) begin
		if (arst_n && result_valid)
			board.check_result(sorted_value, swap_count, compare_count, overflow,
				last_result);
	end

	// Drop start for a number of cycles
	task automatic idle(input int cycles);
		if (cycles > 0) begin
			start <= 1'b0;
			repeat (cycles) @(posedge clk);
		end
	endtask

	// Hold the sender until every queued result has come out
	task automatic wait_drained();
		start <= 1'b0;
		while (board.awaited_sorted.size() != 0)
			@(posedge clk);
	endtask

	// Offer one item and hold it until the core takes it
	task automatic send_item(input logic signed [DATA_W-1:0] v, input logic is_last);
		start     <= 1'b1;
		value     <= v;
		last_item <= is_last;
		do
			@(posedge clk);
		while (busy);
		board.note_item(v, is_last);
		items_sent++;
	endtask

	// Send a set in bursts with random gaps; mark the final element last
	task automatic send_set(input logic signed [DATA_W-1:0] vals[$]);
		for (int k = 0; k < vals.size(); k++) begin
			if (burst_left == 0) begin
				if ($urandom_range(0, 3) == 0)
					burst_left = $urandom_range(16, 40);
				else begin
					idle($urandom_range(0, 5));
					burst_left = $urandom_range(1, 8);
				end
			end
			burst_left--;
			send_item(vals[k], k == vals.size() - 1);
		end
	endtask

	// Mix full-range values, a narrow band for duplicates, and the extremes
	function automatic logic signed [DATA_W-1:0] rand_value();
		case ($urandom_range(0, 5))
			0: return $signed($urandom_range(0, 8)) - 4;
			1: begin
				case ($urandom_range(0, 3))
					0: return {1'b1, {(DATA_W-1){1'b0}}};
					1: return {1'b0, {(DATA_W-1){1'b1}}};
					2: return '0;
					default: return '1;
				endcase
			end
			default: return $urandom;
		endcase
	endfunction

	initial begin
		logic signed [DATA_W-1:0] vals[$];
		int                       set_size;
		int                       random_count;
		board      = new();
		burst_left = 0;
		items_sent = 0;

		// Hold reset, then release it on a clock edge
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Single element set at the top of the range
		vals = '{32'sh7FFF_FFFF};
		send_set(vals);
		// Extremes, zero and neighbors, with repeats
		vals = '{32'sd0, -32'sd1, 32'sd1, 32'sh8000_0000, 32'sh7FFF_FFFF,
			32'sh7FFF_FFFF, 32'sh8000_0000};
		send_set(vals);
		// Strictly descending: every compare swaps
		vals = '{32'sh7FFF_FFFF, 32'sd1000, 32'sd3, 32'sd0, -32'sd1, -32'sd5,
			-32'sd1000, 32'sh8000_0000};
		send_set(vals);
		// Already ascending: no swaps
		vals = '{-32'sd3, -32'sd2, 32'sd5, 32'sd9};
		send_set(vals);
		// All equal: no swaps
		vals = '{32'sd7, 32'sd7, 32'sd7, 32'sd7};
		send_set(vals);

		// Overflow set first, after a full drain; the item marked last is dropped
		wait_drained();
		random_count = 0;
		set_size     = $urandom_range(MAX_ITEMS_DEF + 1, MAX_ITEMS_DEF + 3);
		while (random_count < RANDOM_ITEMS) begin
			vals.delete();
			for (int k = 0; k < set_size; k++)
				vals.push_back(rand_value());
			send_set(vals);
			random_count += set_size;
			if ($urandom_range(0, 4) == 0)
				wait_drained();
			// Mostly small sets; a set at or past capacity only while the budget allows
			if (RANDOM_ITEMS - random_count >= MAX_ITEMS_DEF && $urandom_range(0, 11) == 0)
				set_size = $urandom_range(MAX_ITEMS_DEF, MAX_ITEMS_DEF + 2);
			else
				set_size = $urandom_range(1, 12);
		end

		// Drain the remaining results, then allow the pipeline to settle
		wait_drained();
		repeat (20) @(posedge clk);

		$display("Covered %0d items in %0d sets (%0d with overflow, largest %0d stored),",
			items_sent, board.sets_sorted, board.overflow_sets, board.largest_set);
		$display("and checked %0d sorted results.", board.results_seen);
		if (board.fails == 0 && board.awaited_sorted.size() == 0)
			$display("bubble_sort_swap_count_core regression: pass");
		else
			$display("bubble_sort_swap_count_core regression: fail");
		$finish;
	end

	// End a hung run
	initial begin
		#2_000_000;
		$display("bubble_sort_swap_count_core regression: fail");
		$finish;
	end

endmodule

/* filelist.f */
rtl/bss_pkg.sv
rtl/bss_ram.sv
rtl/bss_cmp_unit.sv
rtl/bubble_sort_swap_count_core.sv
tb/tb_bubble_sort_swap_count_core.sv
